### sv/bpsm_pkg.sv
`timescale 1ns / 1ps
package bpsm_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int BATCH_DEPTH_DEF = 32;
    localparam int NODE_ID_BITS_DEF = 16;
    localparam int MAX_RESULTS = 32;

    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_DESTROY = 2'd1;
    localparam logic [1:0] MODE_COMMIT = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_QUERY = 3'd1;
    localparam logic [2:0] KIND_CREATED = 3'd2;
    localparam logic [2:0] KIND_PERSISTED = 3'd3;
    localparam logic [2:0] KIND_DESTROYED = 3'd4;
    localparam logic [2:0] KIND_EMPTY = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_BATCH_FULL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_WALK,
        S_FREE,
        S_EMPTY
    } state_t;

    // Command broadcast to every cell of the table.
    typedef struct packed {
        logic alloc;
        logic set_batched;
        logic clr_removed;
        logic set_removed;
        logic commit_visit;
        logic free_visit;
    } cell_cmd_t;
endpackage

### sv/bpsm_cell.sv
`timescale 1ns / 1ps
// One table entry. Search flags ripple down the chain combinationally.
module bpsm_cell #(
    parameter int KEY_BITS = 2 * bpsm_pkg::NODE_ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KEY_BITS-1:0] key,
    input  logic                sel,
    input  bpsm_pkg::cell_cmd_t cmd,
    input  logic                hit_in,
    input  logic                free_in,
    output logic                hit_out,
    output logic                free_out,
    output logic                match,
    output logic                first_free,
    output logic [KEY_BITS-1:0] key_q,
    output logic                valid_q,
    output logic [2:0]          marks_q
);
    logic [KEY_BITS-1:0] key_reg;
    logic                valid_reg, valid_next;
    logic [2:0]          marks_reg, marks_next;

    assign match      = valid_reg && key_reg == key;
    assign first_free = !valid_reg && !free_in;
    assign hit_out    = hit_in || match;
    assign free_out   = free_in || !valid_reg;
    assign key_q      = key_reg;
    assign valid_q    = valid_reg;
    assign marks_q    = marks_reg;

    always_comb
    begin
        valid_next = valid_reg;
        marks_next = marks_reg;
        if (sel) begin
            if (cmd.alloc) begin
                valid_next = 1'b1;
                marks_next = 3'b001;
            end
            if (cmd.set_batched) marks_next[0] = 1'b1;
            if (cmd.clr_removed) marks_next[1] = 1'b0;
            if (cmd.set_removed) marks_next[1] = 1'b1;
            if (cmd.commit_visit) begin
                marks_next[0] = 1'b0;
                if (!marks_reg[1]) marks_next[2] = 1'b1;
            end
            if (cmd.free_visit) begin
                valid_next = 1'b0;
                marks_next = 3'b000;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && cmd.alloc) key_reg <= key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            marks_reg <= 3'b000;
        end else begin
            valid_reg <= valid_next;
            marks_reg <= marks_next;
        end
    end
endmodule

### sv/bpsm_chain.sv
`timescale 1ns / 1ps
module bpsm_chain #(
    parameter int TABLE_DEPTH = bpsm_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BITS = 2 * bpsm_pkg::NODE_ID_BITS_DEF,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [KEY_BITS-1:0] key,
    input  logic [IW-1:0]       sel_idx,
    input  bpsm_pkg::cell_cmd_t cmd,
    output logic                hit,
    output logic [IW-1:0]       hit_idx,
    output logic                has_free,
    output logic [IW-1:0]       free_idx,
    output logic [KEY_BITS-1:0] sel_key,
    output logic [2:0]          sel_marks
);
    logic [TABLE_DEPTH:0]  hit_c, free_c;
    logic [TABLE_DEPTH-1:0] match, ffree, valid;
    logic [KEY_BITS-1:0]   keys  [TABLE_DEPTH];
    logic [2:0]            marks [TABLE_DEPTH];

    assign hit_c[0]  = 1'b0;
    assign free_c[0] = 1'b0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        bpsm_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .key        (key),
            .sel        (sel_idx == IW'(g)),
            .cmd        (cmd),
            .hit_in     (hit_c[g]),
            .free_in    (free_c[g]),
            .hit_out    (hit_c[g+1]),
            .free_out   (free_c[g+1]),
            .match      (match[g]),
            .first_free (ffree[g]),
            .key_q      (keys[g]),
            .valid_q    (valid[g]),
            .marks_q    (marks[g])
        );
    end

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (match[i]) hit_idx = IW'(i);
            if (ffree[i]) free_idx = IW'(i);
        end
    end

    assign hit       = hit_c[TABLE_DEPTH];
    assign has_free  = free_c[TABLE_DEPTH];
    assign sel_key   = keys[sel_idx];
    assign sel_marks = valid[sel_idx] ? marks[sel_idx] : 3'b000;
endmodule

### sv/batched_pair_set_manager_core.sv
`timescale 1ns / 1ps
// Pair set manager with batched commit.
// Raise start with mode, node_a and node_b while busy is low; that is the
// input transaction. Create, destroy and query give one result; commit gives
// one result per created, persisted or destroyed pair, or one empty marker.
// Each result shows for one cycle under strobe, last marks the final one.
// The receiver cannot stall, so results are never held.
// Create, destroy and query search the chain of table cells in SEARCH,
// decide in DECIDE and then present the registered result. Busy falls the
// cycle after the result; no new transaction is accepted before that.
// A commit walks the batch memory, one slot a cycle, in WALK, then the
// removed entries in FREE; an empty commit then adds the marker in EMPTY.
// Busy falls the cycle after the last result.
// Reset clears every valid bit and the batch count at once; no sweep.
module batched_pair_set_manager_core #(
    parameter int TABLE_DEPTH = bpsm_pkg::TABLE_DEPTH_DEF,
    parameter int BATCH_DEPTH = bpsm_pkg::BATCH_DEPTH_DEF,
    parameter int NODE_ID_BITS = bpsm_pkg::NODE_ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] node_a,
    input  logic [15:0] node_b,
    output logic        strobe,
    output logic [2:0]  kind,
    output logic [1:0]  status,
    output logic [15:0] first_node,
    output logic [15:0] second_node,
    output logic        present,
    output logic        last
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int KB = 2 * NODE_ID_BITS;
    localparam int CAP = (BATCH_DEPTH < bpsm_pkg::MAX_RESULTS) ? BATCH_DEPTH
                                                              : bpsm_pkg::MAX_RESULTS;
    localparam int BW = $clog2(CAP + 1);
    localparam int SW = (CAP > 1) ? $clog2(CAP) : 1;

    bpsm_pkg::state_t state_reg, state_next;
    bpsm_pkg::cell_cmd_t cmd;
    logic [1:0]    mode_reg;
    logic [KB-1:0] key_reg;
    logic [IW-1:0] sel_idx;
    logic          hit, has_free, hit_reg, free_reg;
    logic [IW-1:0] hit_idx, free_idx, hit_idx_reg, free_idx_reg;
    logic [KB-1:0] sel_key;
    logic [2:0]    sel_marks;
    logic [BW-1:0] count_reg, count_next;
    logic [BW-1:0] pos_reg, pos_next;
    logic [BW-1:0] nrem_reg, nrem_next;
    logic          any_reg, any_next;
    logic [IW-1:0] batch_mem [CAP];
    logic [IW-1:0] rem_mem [CAP];
    logic [IW-1:0] walk_idx, walk_idx_reg;
    logic          batch_we, rem_we;
    logic [IW-1:0] batch_wd;
    logic          out_v;
    logic [2:0]    out_kind;
    logic [1:0]    out_st;
    logic          out_last, out_present;
    logic [NODE_ID_BITS-1:0] a_m, b_m, lo, hi;

    assign a_m = NODE_ID_BITS'(node_a);
    assign b_m = NODE_ID_BITS'(node_b);
    assign lo  = (a_m < b_m) ? a_m : b_m;
    assign hi  = (a_m < b_m) ? b_m : a_m;

    bpsm_chain #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KB)) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       (key_reg),
        .sel_idx   (sel_idx),
        .cmd       (cmd),
        .hit       (hit),
        .hit_idx   (hit_idx),
        .has_free  (has_free),
        .free_idx  (free_idx),
        .sel_key   (sel_key),
        .sel_marks (sel_marks)
    );

    assign walk_idx = walk_idx_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpsm_pkg::S_IDLE:   if (start && !busy) state_next = bpsm_pkg::S_SEARCH;
            bpsm_pkg::S_SEARCH: state_next = (mode_reg == bpsm_pkg::MODE_COMMIT)
                                             ? bpsm_pkg::S_WALK : bpsm_pkg::S_DECIDE;
            bpsm_pkg::S_DECIDE: state_next = bpsm_pkg::S_IDLE;
            bpsm_pkg::S_WALK:   if (pos_reg >= count_reg) state_next = bpsm_pkg::S_FREE;
            bpsm_pkg::S_FREE:   if (pos_reg >= nrem_reg) state_next = any_reg
                                             ? bpsm_pkg::S_IDLE : bpsm_pkg::S_EMPTY;
            bpsm_pkg::S_EMPTY:  state_next = bpsm_pkg::S_IDLE;
            default:            state_next = bpsm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        sel_idx = walk_idx;
        count_next = count_reg;
        pos_next = pos_reg;
        nrem_next = nrem_reg;
        any_next = any_reg;
        batch_we = 1'b0;
        rem_we = 1'b0;
        batch_wd = hit_idx_reg;
        out_v = 1'b0;
        out_kind = bpsm_pkg::KIND_STATUS;
        out_st = bpsm_pkg::ST_OK;
        out_last = 1'b0;
        out_present = 1'b0;
        case (state_reg)
            bpsm_pkg::S_SEARCH:
            begin
                pos_next = '0;
                nrem_next = '0;
                any_next = 1'b0;
            end
            bpsm_pkg::S_DECIDE:
            begin
                out_v = 1'b1;
                out_last = 1'b1;
                sel_idx = hit_idx_reg;
                if (mode_reg == bpsm_pkg::MODE_QUERY) begin
                    out_kind = bpsm_pkg::KIND_QUERY;
                    out_present = hit_reg;
                end else if (mode_reg == bpsm_pkg::MODE_CREATE) begin
                    if (!hit_reg) begin
                        sel_idx = free_idx_reg;
                        batch_wd = free_idx_reg;
                        if (!free_reg) out_st = bpsm_pkg::ST_TABLE_FULL;
                        else if (count_reg >= BW'(CAP)) out_st = bpsm_pkg::ST_BATCH_FULL;
                        else begin
                            cmd.alloc = 1'b1;
                            batch_we = 1'b1;
                        end
                    end else if (!sel_marks[0]) begin
                        if (count_reg >= BW'(CAP)) out_st = bpsm_pkg::ST_BATCH_FULL;
                        else begin
                            cmd.set_batched = 1'b1;
                            cmd.clr_removed = 1'b1;
                            batch_we = 1'b1;
                        end
                    end else cmd.clr_removed = 1'b1;
                end else begin
                    if (!hit_reg) out_st = bpsm_pkg::ST_NOT_FOUND;
                    else if (!sel_marks[0]) begin
                        if (count_reg >= BW'(CAP)) out_st = bpsm_pkg::ST_BATCH_FULL;
                        else begin
                            cmd.set_batched = 1'b1;
                            cmd.set_removed = 1'b1;
                            batch_we = 1'b1;
                        end
                    end else cmd.set_removed = 1'b1;
                end
                if (batch_we) count_next = count_reg + 1'b1;
            end
            bpsm_pkg::S_WALK:
            begin
                if (pos_reg < count_reg) begin
                    cmd.commit_visit = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    if (sel_marks[1]) begin
                        rem_we = 1'b1;
                        nrem_next = nrem_reg + 1'b1;
                    end else begin
                        out_v = 1'b1;
                        any_next = 1'b1;
                        out_kind = sel_marks[2] ? bpsm_pkg::KIND_PERSISTED
                                                : bpsm_pkg::KIND_CREATED;
                    end
                end else begin
                    pos_next = '0;
                    count_next = '0;
                end
            end
            bpsm_pkg::S_FREE:
            begin
                if (pos_reg < nrem_reg) begin
                    cmd.free_visit = 1'b1;
                    pos_next = pos_reg + 1'b1;
                    if (sel_marks[2]) begin
                        out_v = 1'b1;
                        any_next = 1'b1;
                        out_kind = bpsm_pkg::KIND_DESTROYED;
                    end
                end
            end
            bpsm_pkg::S_EMPTY:
            begin
                out_v = 1'b1;
                out_last = 1'b1;
                out_kind = bpsm_pkg::KIND_EMPTY;
            end
            default:
            begin
                out_v = 1'b0;
            end
        endcase
    end

    // The last commit event is only known once the walk ends, so every
    // event is held in the pend registers and last is set when no further one follows.
    logic          pend_v_reg;
    logic [2:0]    pend_kind_reg;
    logic [1:0]    pend_st_reg;
    logic [KB-1:0] pend_key_reg;
    logic          pend_last_reg, pend_present_reg;
    logic          flush;
    logic [KB-1:0] out_key;

    assign out_key = (state_reg == bpsm_pkg::S_WALK || state_reg == bpsm_pkg::S_FREE)
                     ? sel_key
                     : (state_reg == bpsm_pkg::S_EMPTY) ? '0 : key_reg;
    assign flush = (state_reg == bpsm_pkg::S_FREE) && (pos_reg >= nrem_reg);

    always_ff @(posedge clk)
    begin
        if (batch_we) batch_mem[count_reg[SW-1:0]] <= batch_wd;
        if (rem_we) rem_mem[nrem_reg[SW-1:0]] <= walk_idx;
        if (state_next == bpsm_pkg::S_FREE) walk_idx_reg <= rem_mem[pos_next[SW-1:0]];
        else walk_idx_reg <= batch_mem[pos_next[SW-1:0]];
        if (out_v) begin
            pend_kind_reg <= out_kind;
            pend_st_reg <= out_st;
            pend_key_reg <= out_key;
            pend_present_reg <= out_present;
        end
        if (state_reg == bpsm_pkg::S_IDLE && start && !busy) begin
            mode_reg <= mode;
            key_reg <= {lo, hi};
        end
        if (state_reg == bpsm_pkg::S_SEARCH) begin
            hit_reg <= hit;
            hit_idx_reg <= hit_idx;
            free_reg <= has_free;
            free_idx_reg <= free_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= bpsm_pkg::S_IDLE;
            count_reg <= '0;
            pos_reg <= '0;
            nrem_reg <= '0;
            any_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            pend_last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg <= pos_next;
            nrem_reg <= nrem_next;
            any_reg <= any_next;
            if (out_v) begin
                pend_v_reg <= 1'b1;
                pend_last_reg <= out_last;
            end else if (flush) begin
                pend_v_reg <= 1'b0;
                pend_last_reg <= 1'b0;
            end else if (pend_last_reg || state_reg == bpsm_pkg::S_IDLE) begin
                pend_v_reg <= 1'b0;
                pend_last_reg <= 1'b0;
            end
        end
    end

    // A held event leaves as soon as the next one replaces it, or with last
    // at the end of the walk; a single result leaves the cycle after DECIDE.
    assign strobe = pend_v_reg && (out_v || pend_last_reg || flush);
    assign last = pend_last_reg || (flush && !out_v);
    assign kind = pend_kind_reg;
    assign status = pend_st_reg;
    assign first_node = 16'(pend_key_reg[KB-1:NODE_ID_BITS]);
    assign second_node = 16'(pend_key_reg[NODE_ID_BITS-1:0]);
    assign present = pend_present_reg;
    assign busy = (state_reg != bpsm_pkg::S_IDLE) || pend_v_reg;
endmodule

### sv/bpsm_checker.sv
`timescale 1ns / 1ps
module bpsm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic       last,
    input logic [2:0] kind,
    input logic [1:0] status,
    input logic       present
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("result after last");
    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind != bpsm_pkg::KIND_STATUS) |-> status == bpsm_pkg::ST_OK)
        else $error("status on non status result");
    a_present_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && present) |-> kind == bpsm_pkg::KIND_QUERY)
        else $error("present on non query result");
endmodule

bind batched_pair_set_manager_core bpsm_checker u_bpsm_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .strobe  (strobe),
    .last    (last),
    .kind    (kind),
    .status  (status),
    .present (present)
);

### sim/tb.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [15:0] first_node;
    logic [15:0] second_node;
    logic        present;
    logic        last;
} pair_event_t;

class pair_scoreboard;
    localparam int DEPTH = bpsm_pkg::TABLE_DEPTH_DEF;
    localparam int BATCH_CAP = (bpsm_pkg::BATCH_DEPTH_DEF < bpsm_pkg::MAX_RESULTS)
                               ? bpsm_pkg::BATCH_DEPTH_DEF : bpsm_pkg::MAX_RESULTS;
    localparam logic [2:0] M_BATCHED = 3'b001;
    localparam logic [2:0] M_REMOVED = 3'b010;
    localparam logic [2:0] M_PERSIST = 3'b100;

    logic [31:0] keys [DEPTH];
    bit          used [DEPTH];
    logic [2:0]  marks [DEPTH];
    int          batch [$];
    pair_event_t pending_events [$];
    int          mismatches;

    function new();
        foreach (used[i])
        begin
            used[i] = 0;
            marks[i] = '0;
        end
        mismatches = 0;
    endfunction

    function void push_event(logic [2:0] k, logic [1:0] st, logic [31:0] key, logic pr);
        pair_event_t ev;
        ev.kind = k;
        ev.status = st;
        ev.first_node = key[31:16];
        ev.second_node = key[15:0];
        ev.present = pr;
        ev.last = 1'b0;
        pending_events.push_back(ev);
    endfunction

    function int lookup(logic [31:0] key);
        foreach (used[i])
            if (used[i] && keys[i] == key)
                return i;
        return -1;
    endfunction

    function void commit_batch();
        int removed_slots [$];
        int n;
        int s;
        n = 0;
        foreach (batch[i])
        begin
            s = batch[i];
            marks[s] &= ~M_BATCHED;
            if (marks[s] & M_REMOVED)
                removed_slots.push_back(s);
            else if (!(marks[s] & M_PERSIST))
            begin
                marks[s] |= M_PERSIST;
                push_event(bpsm_pkg::KIND_CREATED, bpsm_pkg::ST_OK, keys[s], 1'b0);
                n++;
            end
            else
            begin
                push_event(bpsm_pkg::KIND_PERSISTED, bpsm_pkg::ST_OK, keys[s], 1'b0);
                n++;
            end
        end
        foreach (removed_slots[i])
        begin
            s = removed_slots[i];
            if (marks[s] & M_PERSIST)
            begin
                push_event(bpsm_pkg::KIND_DESTROYED, bpsm_pkg::ST_OK, keys[s], 1'b0);
                n++;
            end
            used[s] = 0;
            marks[s] = '0;
        end
        batch.delete();
        if (n == 0)
            push_event(bpsm_pkg::KIND_EMPTY, bpsm_pkg::ST_OK, 32'd0, 1'b0);
    endfunction

    function void note(logic [1:0] m, logic [15:0] a, logic [15:0] b);
        logic [31:0] key;
        logic [1:0] st;
        int e;
        int f;
        key = (a < b) ? {a, b} : {b, a};
        e = lookup(key);
        st = bpsm_pkg::ST_OK;
        if (m == bpsm_pkg::MODE_COMMIT)
            commit_batch();
        else if (m == bpsm_pkg::MODE_QUERY)
            push_event(bpsm_pkg::KIND_QUERY, bpsm_pkg::ST_OK, key, e >= 0);
        else
        begin
            if (m == bpsm_pkg::MODE_CREATE && e < 0)
            begin
                f = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (!used[i] && f < 0)
                        f = i;
                if (f < 0)
                    st = bpsm_pkg::ST_TABLE_FULL;
                else if (batch.size() >= BATCH_CAP)
                    st = bpsm_pkg::ST_BATCH_FULL;
                else
                begin
                    keys[f] = key;
                    used[f] = 1;
                    marks[f] = M_BATCHED;
                    batch.push_back(f);
                end
            end
            else if (e < 0)
                st = bpsm_pkg::ST_NOT_FOUND;
            else if (!(marks[e] & M_BATCHED))
            begin
                if (batch.size() >= BATCH_CAP)
                    st = bpsm_pkg::ST_BATCH_FULL;
                else
                begin
                    if (m == bpsm_pkg::MODE_CREATE)
                        marks[e] = (marks[e] | M_BATCHED) & ~M_REMOVED;
                    else
                        marks[e] |= M_BATCHED | M_REMOVED;
                    batch.push_back(e);
                end
            end
            else if (m == bpsm_pkg::MODE_CREATE)
                marks[e] &= ~M_REMOVED;
            else
                marks[e] |= M_REMOVED;
            push_event(bpsm_pkg::KIND_STATUS, st, key, 1'b0);
        end
        pending_events[$].last = 1'b1;
    endfunction

    function void check(pair_event_t got);
        pair_event_t want;
        if (pending_events.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: kind %0d pair %0d,%0d", got.kind,
                         got.first_node, got.second_node);
            return;
        end
        want = pending_events.pop_front();
        if (got != want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"Mismatch: expected k%0d s%0d %0d,%0d p%0d l%0d",
                          " got k%0d s%0d %0d,%0d p%0d l%0d"},
                         want.kind, want.status, want.first_node, want.second_node,
                         want.present, want.last, got.kind, got.status, got.first_node,
                         got.second_node, got.present, got.last);
        end
    endfunction
endclass

module tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  mode = bpsm_pkg::MODE_QUERY;
    logic [15:0] node_a = '0;
    logic [15:0] node_b = '0;
    logic        strobe;
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [15:0] first_node;
    logic [15:0] second_node;
    logic        present;
    logic        last;

    pair_scoreboard sb = new();
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;

    batched_pair_set_manager_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .node_a(node_a), .node_b(node_b), .strobe(strobe), .kind(kind),
        .status(status), .first_node(first_node), .second_node(second_node),
        .present(present), .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check('{kind, status, first_node, second_node, present, last});
        if (!rst_n || strobe || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send(input logic [1:0] m, input logic [15:0] a, input logic [15:0] b);
        if (gap_left > 0)
        begin
            start <= 1'b0;
            while (gap_left > 0)
            begin
                @(posedge clk);
                gap_left--;
            end
        end
        start <= 1'b1;
        mode <= m;
        node_a <= a;
        node_b <= b;
        do
            @(posedge clk);
        while (busy);
        sb.note(m, a, b);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end
    endtask

    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom_range(0, 65535));
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 7));
        endcase
    endfunction

    initial
    begin
        logic [1:0] m;
        int r;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(bpsm_pkg::MODE_QUERY, 16'd5, 16'd3);
        send(bpsm_pkg::MODE_DESTROY, 16'd5, 16'd3);
        send(bpsm_pkg::MODE_COMMIT, 16'd0, 16'd0);
        send(bpsm_pkg::MODE_CREATE, 16'd5, 16'd3);
        send(bpsm_pkg::MODE_CREATE, 16'd3, 16'd5);
        send(bpsm_pkg::MODE_CREATE, 16'hFFFF, 16'd0);
        send(bpsm_pkg::MODE_CREATE, 16'd7, 16'd7);
        send(bpsm_pkg::MODE_QUERY, 16'd3, 16'd5);
        send(bpsm_pkg::MODE_QUERY, 16'd0, 16'hFFFF);
        send(bpsm_pkg::MODE_COMMIT, 16'hFFFF, 16'hFFFF);
        send(bpsm_pkg::MODE_CREATE, 16'd5, 16'd3);
        send(bpsm_pkg::MODE_DESTROY, 16'd7, 16'd7);
        send(bpsm_pkg::MODE_CREATE, 16'd7, 16'd7);
        send(bpsm_pkg::MODE_DESTROY, 16'd0, 16'hFFFF);
        send(bpsm_pkg::MODE_CREATE, 16'd1, 16'd2);
        send(bpsm_pkg::MODE_DESTROY, 16'd2, 16'd1);
        send(bpsm_pkg::MODE_COMMIT, 16'd0, 16'd0);
        send(bpsm_pkg::MODE_CREATE, 16'd9, 16'd8);
        send(bpsm_pkg::MODE_DESTROY, 16'd9, 16'd8);
        send(bpsm_pkg::MODE_COMMIT, 16'd0, 16'd0);
        send(bpsm_pkg::MODE_QUERY, 16'hFFFF, 16'd0);

        for (int i = 0; i < 33; i++)
            send(bpsm_pkg::MODE_CREATE, 16'(i + 256), 16'hAAAA ^ 16'(i));
        send(bpsm_pkg::MODE_COMMIT, 16'd0, 16'd0);
        for (int i = 0; i < 33; i++)
            send(bpsm_pkg::MODE_DESTROY, 16'(i + 256), 16'hAAAA ^ 16'(i));
        send(bpsm_pkg::MODE_COMMIT, 16'd0, 16'd0);

        for (int n = 0; n < 40; n++)
        begin
            r = $urandom_range(0, 99);
            m = (r < 40) ? bpsm_pkg::MODE_CREATE : (r < 65) ? bpsm_pkg::MODE_DESTROY :
                (r < 85) ? bpsm_pkg::MODE_QUERY : bpsm_pkg::MODE_COMMIT;
            send(m, pick_id(), pick_id());
        end
        send(bpsm_pkg::MODE_COMMIT, 16'd0, 16'd0);
        start <= 1'b0;

        while (sb.pending_events.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_events.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

### batched_pair_set_manager_core.f
sv/bpsm_pkg.sv
sv/bpsm_cell.sv
sv/bpsm_chain.sv
sv/batched_pair_set_manager_core.sv
sv/bpsm_checker.sv
sim/tb.sv
